// ----- hw/rtl/ptc_pkg.sv -----
// ptc_pkg: shared widths, constants and register indexes for the
// pressure/temperature compensation pipeline. No dependencies.
package ptc_pkg;

    // field widths
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int TEMP_W  = 15;
    localparam int PRES_W  = 17;

    // internal widths
    localparam int DT_W    = 25;   // raw_temperature - c5*256
    localparam int PROD_W  = 42;   // dt times a calibration word
    localparam int TSUM_W  = 20;   // temperature before clamping
    localparam int OS_W    = 38;   // offset and sensitivity
    localparam int SLO_W   = 18;   // low part of sensitivity
    localparam int PLO_W   = 44;   // d1 * low part
    localparam int PHI_W   = 45;   // d1 * high part
    localparam int FULL_W  = 63;   // d1 * sensitivity
    localparam int DIFF_W  = 43;   // scaled product minus offset
    localparam int PRAW_W  = 28;   // pressure before clamping

    // register index codes
    localparam logic [2:0] REG_PRES_SENS = 3'd0;
    localparam logic [2:0] REG_PRES_OFF  = 3'd1;
    localparam logic [2:0] REG_SENS_TC   = 3'd2;
    localparam logic [2:0] REG_OFF_TC    = 3'd3;
    localparam logic [2:0] REG_REF_TEMP  = 3'd4;
    localparam logic [2:0] REG_TEMP_COEF = 3'd5;

    // formula constants and output spans
    localparam logic signed [TSUM_W-1:0] TEMP_BASE = 20'sd2000;
    localparam logic signed [TSUM_W-1:0] TEMP_MIN  = -20'sd4000;
    localparam logic signed [TSUM_W-1:0] TEMP_MAX  = 20'sd8500;
    localparam logic signed [PRAW_W-1:0] PRES_MIN  = 28'sd1000;
    localparam logic signed [PRAW_W-1:0] PRES_MAX  = 28'sd120000;

endpackage

// ----- hw/rtl/pressure_temperature_compensation.sv -----
// pressure_temperature_compensation: first-order barometric compensation,
// six-stage pipeline with stream ports and a calibration write port.
// Depends on ptc_pkg.
//
// Throughput: one item per cycle; all stages advance together whenever the
// output register is empty or being taken, so a stall freezes the whole pipe.
// Reset (aresetn low, synchronous) clears every stage valid bit and sets all
// six calibration words to zero.
module pressure_temperature_compensation
    import ptc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // calibration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // raw_pressure [23:0], raw_temperature [47:24]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // temperature_centi [14:0], pressure_centi [31:15]
    output logic        m_axis_tuser    // out_of_range
);

    // calibration words
    logic [CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_PRES_SENS: c1_reg <= cfg_wdata;
                REG_PRES_OFF:  c2_reg <= cfg_wdata;
                REG_SENS_TC:   c3_reg <= cfg_wdata;
                REG_OFF_TC:    c4_reg <= cfg_wdata;
                REG_REF_TEMP:  c5_reg <= cfg_wdata;
                REG_TEMP_COEF: c6_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic       adv;
    logic [5:0] valid_reg;

    assign adv           = !valid_reg[5] || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[4:0], s_axis_tvalid};
        end
    end

    // stage 1: temperature difference
    logic        [RAW_W-1:0] d1_s1_reg;
    logic signed [DT_W-1:0]  dt_reg, dt_next;

    assign dt_next = $signed({1'b0, s_axis_tdata[47:24]}) - $signed({1'b0, c5_reg, 8'h00});

    // stage 2: products with dt
    logic        [RAW_W-1:0]  d1_s2_reg;
    logic signed [PROD_W-1:0] pt_reg, pt_next;
    logic signed [PROD_W-1:0] po_reg, po_next;
    logic signed [PROD_W-1:0] ps_reg, ps_next;

    assign pt_next = dt_reg * $signed({1'b0, c6_reg});
    assign po_next = dt_reg * $signed({1'b0, c4_reg});
    assign ps_next = dt_reg * $signed({1'b0, c3_reg});

    // stage 3: temperature, offset and sensitivity
    logic        [RAW_W-1:0]  d1_s3_reg;
    logic signed [PROD_W-1:0] pt_sh, po_sh, ps_sh;
    logic signed [TSUM_W-1:0] temp_s3_reg, temp_next;
    logic signed [OS_W-1:0]   off_s3_reg, off_next;
    logic signed [OS_W-1:0]   sens_reg, sens_next;

    assign pt_sh     = pt_reg >>> 23;
    assign po_sh     = po_reg >>> 6;
    assign ps_sh     = ps_reg >>> 7;
    assign temp_next = pt_sh[TSUM_W-1:0] + TEMP_BASE;
    assign off_next  = $signed({5'b0, c2_reg, 17'b0}) + po_sh[OS_W-1:0];
    assign sens_next = $signed({6'b0, c1_reg, 16'b0}) + ps_sh[OS_W-1:0];

    // stage 4: d1 times sensitivity, split into two partial products
    logic signed [TSUM_W-1:0] temp_s4_reg;
    logic signed [OS_W-1:0]   off_s4_reg;
    logic signed [PLO_W-1:0]  plo_reg, plo_next;
    logic signed [PHI_W-1:0]  phi_reg, phi_next;

    assign plo_next = $signed({1'b0, d1_s3_reg}) * $signed({1'b0, sens_reg[SLO_W-1:0]});
    assign phi_next = $signed(sens_reg[OS_W-1:SLO_W]) * $signed({1'b0, d1_s3_reg});

    // stage 5: recombine the partial products
    logic signed [TSUM_W-1:0] temp_s5_reg;
    logic signed [OS_W-1:0]   off_s5_reg;
    logic signed [FULL_W-1:0] full_reg, full_next;

    assign full_next = $signed({phi_reg, 18'b0}) + $signed({19'b0, plo_reg});

    // stage 6: pressure, clamping and output register
    logic signed [FULL_W-1:0] full_sh;
    logic signed [DIFF_W-1:0] diff, diff_sh;
    logic signed [PRAW_W-1:0] pres_raw;
    logic signed [TSUM_W-1:0] temp_clamped;
    logic signed [PRAW_W-1:0] pres_clamped;
    logic                     temp_sat, pres_sat;
    logic [TEMP_W-1:0]        temp_out_reg;
    logic [PRES_W-1:0]        pres_out_reg;
    logic                     oor_reg;

    assign full_sh  = full_reg >>> 21;
    assign diff     = full_sh[DIFF_W-1:0] - {{(DIFF_W-OS_W){off_s5_reg[OS_W-1]}}, off_s5_reg};
    assign diff_sh  = diff >>> 15;
    assign pres_raw = diff_sh[PRAW_W-1:0];

    // saturate each result to its rated span
    always_comb begin
        temp_sat     = 1'b0;
        temp_clamped = temp_s5_reg;
        if (temp_s5_reg < TEMP_MIN) begin
            temp_sat     = 1'b1;
            temp_clamped = TEMP_MIN;
        end else if (temp_s5_reg > TEMP_MAX) begin
            temp_sat     = 1'b1;
            temp_clamped = TEMP_MAX;
        end
        pres_sat     = 1'b0;
        pres_clamped = pres_raw;
        if (pres_raw < PRES_MIN) begin
            pres_sat     = 1'b1;
            pres_clamped = PRES_MIN;
        end else if (pres_raw > PRES_MAX) begin
            pres_sat     = 1'b1;
            pres_clamped = PRES_MAX;
        end
    end

    // datapath registers, moved only when the pipe advances
    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_s1_reg    <= s_axis_tdata[23:0];
            dt_reg       <= dt_next;
            d1_s2_reg    <= d1_s1_reg;
            pt_reg       <= pt_next;
            po_reg       <= po_next;
            ps_reg       <= ps_next;
            d1_s3_reg    <= d1_s2_reg;
            temp_s3_reg  <= temp_next;
            off_s3_reg   <= off_next;
            sens_reg     <= sens_next;
            temp_s4_reg  <= temp_s3_reg;
            off_s4_reg   <= off_s3_reg;
            plo_reg      <= plo_next;
            phi_reg      <= phi_next;
            temp_s5_reg  <= temp_s4_reg;
            off_s5_reg   <= off_s4_reg;
            full_reg     <= full_next;
            temp_out_reg <= temp_clamped[TEMP_W-1:0];
            pres_out_reg <= pres_clamped[PRES_W-1:0];
            oor_reg      <= temp_sat | pres_sat;
        end
    end

    assign m_axis_tvalid = valid_reg[5];
    assign m_axis_tdata  = {pres_out_reg, temp_out_reg};
    assign m_axis_tuser  = oor_reg;

    // checks
    a_temp_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ($signed(temp_out_reg) >= -15'sd4000)
                          && ($signed(temp_out_reg) <= 15'sd8500))
        else $error("temperature result outside rated span");

    a_pres_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (pres_out_reg >= 17'd1000) && (pres_out_reg <= 17'd120000))
        else $error("pressure result outside rated span");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> valid_reg[0])
        else $error("accepted item did not enter the first stage");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(valid_reg) && $stable(full_reg))
        else $error("pipeline moved during a stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result item valid straight after reset");

endmodule
